>>> hdl/cep_pkg.sv
`timescale 1ns / 1ps

package cep_pkg;

  // Width of the coordinate fields on the point and corner channels.
  localparam int PORT_COORD_W = 12;

  // Default internal coordinate width.
  localparam int COORD_BITS_DEFAULT = 12;

  // Number of tracked extreme points.
  localparam int NUM_SLOTS = 8;
  localparam int SLOT_IDX_W = 3;

  // Slot order, which is also the order in which corners leave the block.
  localparam logic [SLOT_IDX_W-1:0] SLOT_UMIN_VMIN = 3'd0;
  localparam logic [SLOT_IDX_W-1:0] SLOT_UMIN_VMAX = 3'd1;
  localparam logic [SLOT_IDX_W-1:0] SLOT_UMAX_VMIN = 3'd2;
  localparam logic [SLOT_IDX_W-1:0] SLOT_UMAX_VMAX = 3'd3;
  localparam logic [SLOT_IDX_W-1:0] SLOT_VMIN_UMAX = 3'd4;
  localparam logic [SLOT_IDX_W-1:0] SLOT_VMIN_UMIN = 3'd5;
  localparam logic [SLOT_IDX_W-1:0] SLOT_VMAX_UMAX = 3'd6;
  localparam logic [SLOT_IDX_W-1:0] SLOT_VMAX_UMIN = 3'd7;

  // Configuration port.
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic REG_DIAGONAL_MODE = 1'b0;  // word index, taken from paddr[2]

endpackage

>>> hdl/cep_point_if.sv
`timescale 1ns / 1ps

interface cep_point_if;
  logic                              valid;
  logic                              ready;
  logic [cep_pkg::PORT_COORD_W-1:0] point_x;
  logic [cep_pkg::PORT_COORD_W-1:0] point_y;
  logic                              last_point;

  modport source (output valid, point_x, point_y, last_point, input ready);
  modport sink (input valid, point_x, point_y, last_point, output ready);
endinterface

>>> hdl/cep_corner_if.sv
`timescale 1ns / 1ps

interface cep_corner_if;
  logic                              valid;
  logic                              ready;
  logic [cep_pkg::PORT_COORD_W-1:0] corner_x;
  logic [cep_pkg::PORT_COORD_W-1:0] corner_y;
  logic                              last_corner;

  modport source (output valid, corner_x, corner_y, last_corner, input ready);
  modport sink (input valid, corner_x, corner_y, last_corner, output ready);
endinterface

>>> hdl/contour_extreme_points.sv
`timescale 1ns / 1ps

// Contour extreme-point corner finder.
//
// Points of one contour arrive as words on the points channel (valid/ready),
// with last_point set on the contour's final point. Each point updates eight
// extreme points (topmost and bottommost of the leftmost and rightmost
// columns, leftmost and rightmost of the top and bottom rows; in diagonal
// mode the same along axes rotated by 45 degrees). On the last point the
// distinct extreme points leave on the corners channel, one word each, in a
// fixed slot order, with last_corner set on the final word of the contour.
//
// Throughput: one point word per cycle while no last point waits, set by the
// joint update of the eight slot registers. A last point waits in staging
// until the emitter has loaded the previous contour's final corner into its
// output register; the emitter first takes the slot snapshot, then loads at
// most one corner a cycle. With the emitter free, a last point passes the
// staging and snapshot registers before its first corner is output. A stalled
// receiver freezes the output register, and the staging register keeps taking
// points until another last point arrives. Reset clears the handshake state,
// slots, contour-started flag and diagonal_mode, which is written over APB at
// byte address 0 by the user only while idle; the block does not enforce it.

module contour_extreme_points #(
  parameter int COORD_BITS = cep_pkg::COORD_BITS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  cep_point_if.sink                        points,
  cep_corner_if.source                     corners,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [cep_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [cep_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [cep_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready
);

  logic                                         diagonal_mode;
  logic                                         emit_free;
  logic                                         snap_valid;
  logic [cep_pkg::NUM_SLOTS-1:0][2*COORD_BITS-1:0] snap_points;

  // Configuration register. paddr[2] is the word index; the byte offset bits
  // do not take part in the decode.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      diagonal_mode <= 1'b0;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == cep_pkg::REG_DIAGONAL_MODE) begin
      diagonal_mode <= pwdata[0];
    end
  end

  assign prdata = (paddr[2] == cep_pkg::REG_DIAGONAL_MODE) ?
                  cep_pkg::APB_DATA_W'(diagonal_mode) : '0;

  // Staging register, slot registers and the per-point compare logic.
  cep_tracker #(
    .COORD_BITS (COORD_BITS)
  ) u_tracker (
    .clk           (clk),
    .rst           (rst),
    .diagonal_mode (diagonal_mode),
    .points        (points),
    .emit_free     (emit_free),
    .snap_valid    (snap_valid),
    .snap_points   (snap_points)
  );

  // Snapshot of the finished contour, duplicate removal and output register.
  cep_emitter #(
    .COORD_BITS (COORD_BITS)
  ) u_emitter (
    .clk         (clk),
    .rst         (rst),
    .snap_valid  (snap_valid),
    .snap_points (snap_points),
    .emit_free   (emit_free),
    .corners     (corners)
  );

endmodule

>>> hdl/cep_tracker.sv
`timescale 1ns / 1ps

module cep_tracker #(
  parameter int COORD_BITS = cep_pkg::COORD_BITS_DEFAULT
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        diagonal_mode,
  cep_point_if.sink                                   points,
  input  logic                                        emit_free,
  output logic                                        snap_valid,
  output logic [cep_pkg::NUM_SLOTS-1:0][2*COORD_BITS-1:0] snap_points
);

  localparam int KW = COORD_BITS + 1;
  localparam int PW = 2 * COORD_BITS;
  localparam int NS = cep_pkg::NUM_SLOTS;

  // Point staging register.
  logic                  st_valid;
  logic [COORD_BITS-1:0] st_x;
  logic [COORD_BITS-1:0] st_y;
  logic                  st_last;
  logic                  st_go;

  logic                  started;
  logic [NS-1:0][PW-1:0] slot;
  logic [NS-1:0][PW-1:0] slot_next;

  logic [KW-1:0]         pu;
  logic [KW-1:0]         pv;
  logic [NS-1:0][KW-1:0] su;
  logic [NS-1:0][KW-1:0] sv;
  logic [PW-1:0]         pt;

  function automatic logic [KW-1:0] key_u(input logic [COORD_BITS-1:0] x,
                                         input logic [COORD_BITS-1:0] y,
                                         input logic diag);
    key_u = diag ? (KW'(x) + KW'(y)) : KW'(x);
  endfunction

  // y - x offset by 2^COORD_BITS so it never goes negative.
  function automatic logic [KW-1:0] key_v(input logic [COORD_BITS-1:0] x,
                                         input logic [COORD_BITS-1:0] y,
                                         input logic diag);
    key_v = diag ? (KW'(y) - KW'(x) + (KW'(1) << COORD_BITS)) : KW'(y);
  endfunction

  // A last point waits here while the previous contour's corners still drain.
  assign st_go        = st_valid && !(st_last && !emit_free);
  assign points.ready = !st_valid || st_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
    end else if (points.ready) begin
      st_valid <= points.valid;
    end
    if (points.ready && points.valid) begin
      st_x    <= COORD_BITS'({{COORD_BITS{1'b0}}, points.point_x});
      st_y    <= COORD_BITS'({{COORD_BITS{1'b0}}, points.point_y});
      st_last <= points.last_point;
    end
  end

  assign pt = {st_y, st_x};
  assign pu = key_u(st_x, st_y, diagonal_mode);
  assign pv = key_v(st_x, st_y, diagonal_mode);

  always_comb begin
    for (int i = 0; i < NS; i++) begin
      su[i] = key_u(slot[i][COORD_BITS-1:0], slot[i][PW-1:COORD_BITS], diagonal_mode);
      sv[i] = key_v(slot[i][COORD_BITS-1:0], slot[i][PW-1:COORD_BITS], diagonal_mode);
    end
  end

  // All compares read the old slot values; each group writes only its own pair.
  always_comb begin
    slot_next = slot;
    if (st_go) begin
      if (!started) begin
        for (int i = 0; i < NS; i++) begin
          slot_next[i] = pt;
        end
      end else begin
        if (pu < su[cep_pkg::SLOT_UMIN_VMIN]) begin
          slot_next[cep_pkg::SLOT_UMIN_VMIN] = pt;
          slot_next[cep_pkg::SLOT_UMIN_VMAX] = pt;
        end else if (pu == su[cep_pkg::SLOT_UMIN_VMIN]) begin
          if (pv > sv[cep_pkg::SLOT_UMIN_VMAX]) begin
            slot_next[cep_pkg::SLOT_UMIN_VMAX] = pt;
          end else if (pv < sv[cep_pkg::SLOT_UMIN_VMIN]) begin
            slot_next[cep_pkg::SLOT_UMIN_VMIN] = pt;
          end
        end

        if (pu > su[cep_pkg::SLOT_UMAX_VMIN]) begin
          slot_next[cep_pkg::SLOT_UMAX_VMIN] = pt;
          slot_next[cep_pkg::SLOT_UMAX_VMAX] = pt;
        end else if (pu == su[cep_pkg::SLOT_UMAX_VMIN]) begin
          if (pv > sv[cep_pkg::SLOT_UMAX_VMAX]) begin
            slot_next[cep_pkg::SLOT_UMAX_VMAX] = pt;
          end else if (pv < sv[cep_pkg::SLOT_UMAX_VMIN]) begin
            slot_next[cep_pkg::SLOT_UMAX_VMIN] = pt;
          end
        end

        if (pv < sv[cep_pkg::SLOT_VMIN_UMAX]) begin
          slot_next[cep_pkg::SLOT_VMIN_UMAX] = pt;
          slot_next[cep_pkg::SLOT_VMIN_UMIN] = pt;
        end else if (pv == sv[cep_pkg::SLOT_VMIN_UMAX]) begin
          if (pu > su[cep_pkg::SLOT_VMIN_UMAX]) begin
            slot_next[cep_pkg::SLOT_VMIN_UMAX] = pt;
          end else if (pu < su[cep_pkg::SLOT_VMIN_UMIN]) begin
            slot_next[cep_pkg::SLOT_VMIN_UMIN] = pt;
          end
        end

        if (pv > sv[cep_pkg::SLOT_VMAX_UMAX]) begin
          slot_next[cep_pkg::SLOT_VMAX_UMAX] = pt;
          slot_next[cep_pkg::SLOT_VMAX_UMIN] = pt;
        end else if (pv == sv[cep_pkg::SLOT_VMAX_UMAX]) begin
          if (pu > su[cep_pkg::SLOT_VMAX_UMAX]) begin
            slot_next[cep_pkg::SLOT_VMAX_UMAX] = pt;
          end else if (pu < su[cep_pkg::SLOT_VMAX_UMIN]) begin
            slot_next[cep_pkg::SLOT_VMAX_UMIN] = pt;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started <= 1'b0;
      slot    <= '0;
    end else begin
      slot <= slot_next;
      if (st_go) begin
        started <= !st_last;
      end
    end
  end

  assign snap_valid  = st_go && st_last;
  assign snap_points = slot_next;

endmodule

>>> hdl/cep_emitter.sv
`timescale 1ns / 1ps

module cep_emitter #(
  parameter int COORD_BITS = cep_pkg::COORD_BITS_DEFAULT
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        snap_valid,
  input  logic [cep_pkg::NUM_SLOTS-1:0][2*COORD_BITS-1:0] snap_points,
  output logic                                        emit_free,
  cep_corner_if.source                                corners
);

  localparam int PW = 2 * COORD_BITS;
  localparam int NS = cep_pkg::NUM_SLOTS;
  localparam int PC = cep_pkg::PORT_COORD_W;

  logic [NS-1:0][PW-1:0]         held;
  logic [NS-1:0]                 pending;
  logic [NS-1:0]                 distinct;
  logic [NS-1:0]                 eligible;
  logic [NS-1:0]                 rest;
  logic [cep_pkg::SLOT_IDX_W-1:0] sel;
  logic                          busy;
  logic                          take;

  logic                          out_valid;
  logic [PW-1:0]                 out_point;
  logic                          out_last;

  // A slot is a corner of its own only if no earlier slot holds the same point.
  always_comb begin
    for (int i = 0; i < NS; i++) begin
      distinct[i] = 1'b1;
      for (int j = 0; j < i; j++) begin
        if (held[j] == held[i]) begin
          distinct[i] = 1'b0;
        end
      end
    end
  end

  assign eligible = pending & distinct;
  assign rest     = eligible & (eligible - NS'(1));
  assign busy     = |eligible;
  assign emit_free = !busy;
  assign take     = busy && (!out_valid || corners.ready);

  always_comb begin
    sel = '0;
    for (int i = NS - 1; i >= 0; i--) begin
      if (eligible[i]) begin
        sel = cep_pkg::SLOT_IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (snap_valid) begin
        pending <= '1;
      end else if (take) begin
        pending <= rest;
      end
      if (take) begin
        out_valid <= 1'b1;
      end else if (corners.ready) begin
        out_valid <= 1'b0;
      end
    end
    if (snap_valid) begin
      held <= snap_points;
    end
    if (take) begin
      out_point <= held[sel];
      out_last  <= (rest == '0);
    end
  end

  assign corners.valid       = out_valid;
  assign corners.corner_x    = PC'({{PC{1'b0}}, out_point[COORD_BITS-1:0]});
  assign corners.corner_y    = PC'({{PC{1'b0}}, out_point[PW-1:COORD_BITS]});
  assign corners.last_corner = out_last;

endmodule
